@@ rtl/lkvc_pkg.sv @@
// Package with the request types and fixed field widths of the LRU key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W      = 16;
    localparam int VALUE_W    = 31;
    localparam int CAP_W      = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic
    {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t              func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Top level of the fully associative LRU key-value cache with age-rank replacement.
// A request is registered in the request register; lookup, replacement and age update lie between
// the request register and the result register. One request per cycle is taken while the result
// is not stalled.
// A stalled result holds its register while one more request waits in the request register.
// Reset empties the store and sets the capacity to 16; a capacity write also empties it.
`timescale 1ns / 1ps

module lru_key_value_cache #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]           cfg_wr_data,   // capacity

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lkvc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // key, value, zero pad
    input  logic                                 s_axis_tuser,  // func

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lkvc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // read_value, zero pad
    output logic                                 m_axis_tuser   // found
);

    localparam int KW = (KEY_BITS < lkvc_pkg::KEY_W) ? KEY_BITS : lkvc_pkg::KEY_W;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int VW = lkvc_pkg::VALUE_W;

    logic [lkvc_pkg::CAP_W-1:0] cap_reg;

    logic                in_valid_reg;
    lkvc_pkg::req_t      req_reg;

    logic                out_valid_reg;
    logic                found_reg;
    logic [VW-1:0]       rdata_reg;

    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [KW-1:0]       key_reg   [ENTRIES];
    logic [KW-1:0]       key_next  [ENTRIES];
    logic [VW-1:0]       data_reg  [ENTRIES];
    logic [VW-1:0]       data_next [ENTRIES];
    logic [AW-1:0]       age_reg   [ENTRIES];
    logic [AW-1:0]       age_next  [ENTRIES];
    logic [OW-1:0]       occ_reg;
    logic [OW-1:0]       occ_next;

    logic                process;
    logic                is_put;
    logic [ENTRIES-1:0]  hit_vec;
    logic                hit_any;
    logic [AW-1:0]       hit_age;
    logic [VW-1:0]       hit_data;
    logic [OW-1:0]       eff_cap;
    logic                full;
    logic [AW-1:0]       oldest_age;
    logic [ENTRIES-1:0]  evict_vec;
    logic [ENTRIES-1:0]  valid_mid;
    logic [ENTRIES-1:0]  ins_vec;

    assign process       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || process;
    assign is_put        = (req_reg.func == lkvc_pkg::FUNC_PUT);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = found_reg;
    assign m_axis_tdata  = {{(lkvc_pkg::OUT_DATA_W - VW){1'b0}}, rdata_reg};

    // A capacity of zero acts as one, and one above the entry count acts as the entry count.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = OW'(1);
        end
        else if (32'(cap_reg) > 32'(ENTRIES))
        begin
            eff_cap = OW'(ENTRIES);
        end
        else
        begin
            eff_cap = OW'(cap_reg);
        end
    end

    assign full       = (occ_reg >= eff_cap);
    assign oldest_age = AW'(occ_reg - OW'(1));

    always_comb
    begin
        hit_age  = '0;
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]   = valid_reg[i] && (key_reg[i] == req_reg.key[KW-1:0]);
            evict_vec[i] = full && valid_reg[i] && (age_reg[i] == oldest_age);
            if (hit_vec[i])
            begin
                hit_age  = hit_age | age_reg[i];
                hit_data = hit_data | data_reg[i];
            end
        end
    end

    assign hit_any   = |hit_vec;
    assign valid_mid = valid_reg & ~evict_vec;
    // The lowest free slot after an eviction, as a one-hot vector.
    assign ins_vec   = ~valid_mid & (valid_mid + ENTRIES'(1));

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_next[i]  = key_reg[i];
            data_next[i] = data_reg[i];
            age_next[i]  = age_reg[i];
        end

        if (cfg_wr_en)
        begin
            valid_next = '0;
            occ_next   = '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_next[i] = '0;
            end
        end
        else if (process)
        begin
            if (hit_any)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (hit_vec[i])
                    begin
                        age_next[i] = '0;
                        if (is_put)
                        begin
                            data_next[i] = req_reg.value;
                        end
                    end
                    else if (valid_reg[i] && (age_reg[i] < hit_age))
                    begin
                        age_next[i] = age_reg[i] + AW'(1);
                    end
                end
            end
            else if (is_put)
            begin
                valid_next = valid_mid | ins_vec;
                if (!full)
                begin
                    occ_next = occ_reg + OW'(1);
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (ins_vec[i])
                    begin
                        key_next[i]  = req_reg.key[KW-1:0];
                        data_next[i] = req_reg.value;
                        age_next[i]  = '0;
                    end
                    else if (valid_mid[i])
                    begin
                        age_next[i] = age_reg[i] + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkvc_pkg::CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (process)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg.func  <= lkvc_pkg::func_t'(s_axis_tuser);
            req_reg.key   <= s_axis_tdata[lkvc_pkg::KEY_W-1:0];
            req_reg.value <= s_axis_tdata[lkvc_pkg::KEY_W +: VW];
        end
        if (process)
        begin
            found_reg <= hit_any;
            rdata_reg <= (hit_any && !is_put) ? hit_data : '0;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i]  <= key_next[i];
            data_reg[i] <= data_next[i];
        end
    end

    // The fill count always matches the number of valid entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match the valid entries");

    // Keys are unique, so a lookup hits at most one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(hit_vec))
        else $error("key matched more than one entry");

    // An insert into a full store evicts exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && !cfg_wr_en && is_put && !hit_any && full) |-> $onehot(evict_vec))
        else $error("no unique oldest entry to evict");

    // An insert always finds a free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && !cfg_wr_en && is_put && !hit_any) |-> $onehot(ins_vec))
        else $error("no free slot for an insert");

    // A capacity write empties the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (occ_reg == '0) && (valid_reg == '0))
        else $error("store not cleared by a capacity write");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the LRU key-value cache, with stream driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 7;
    localparam int HOLD_CYCLES = 80;

    typedef struct
    {
        logic                         found;
        logic [lkvc_pkg::VALUE_W-1:0] read_value;
    } lookup_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [lkvc_pkg::CAP_W-1:0]      cfg_wr_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [lkvc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [lkvc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;

    lkvc_pkg::req_t pending_reqs[$];
    lookup_result_t expected_results[$];

    logic                         slot_valid [ENTRIES];
    logic [lkvc_pkg::KEY_W-1:0]   slot_key   [ENTRIES];
    logic [lkvc_pkg::VALUE_W-1:0] slot_value [ENTRIES];
    logic [3:0]                   slot_age   [ENTRIES];
    int                           slot_count;
    logic [lkvc_pkg::CAP_W-1:0]   capacity_reg;

    logic [lkvc_pkg::KEY_W-1:0] key_pool [32];

    int   error_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_requests;
    int   hold_served;
    int   hold_left;
    logic req_taken;
    logic offer_busy;

    lru_key_value_cache u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic void clear_cache();
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_age[i]   = '0;
        end
        slot_count = 0;
    endfunction

    function automatic lookup_result_t cache_access(lkvc_pkg::req_t r);
        lookup_result_t res;
        int             hit;
        int             limit;
        int             oldest;
        logic [3:0]     old_age;
        res.found      = 1'b0;
        res.read_value = '0;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && slot_valid[i] && slot_key[i] == r.key)
                hit = i;
        if (hit >= 0)
        begin
            res.found = 1'b1;
            if (r.func == lkvc_pkg::FUNC_GET)
                res.read_value = slot_value[hit];
            else
                slot_value[hit] = r.value;
            old_age = slot_age[hit];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && slot_age[i] < old_age)
                    slot_age[i] = slot_age[i] + 1'b1;
            slot_age[hit] = '0;
        end
        else if (r.func == lkvc_pkg::FUNC_PUT)
        begin
            limit = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
            while (slot_count >= limit && slot_count > 0)
            begin
                oldest = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_valid[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                        oldest = i;
                slot_valid[oldest] = 1'b0;
                slot_age[oldest]   = '0;
                slot_count--;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (hit < 0 && !slot_valid[i])
                    hit = i;
            if (hit >= 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_valid[i])
                        slot_age[i] = slot_age[i] + 1'b1;
                slot_valid[hit] = 1'b1;
                slot_key[hit]   = r.key;
                slot_value[hit] = r.value;
                slot_age[hit]   = '0;
                slot_count++;
            end
        end
        return res;
    endfunction

    task automatic push_req(input lkvc_pkg::func_t f, input logic [lkvc_pkg::KEY_W-1:0] k,
                            input logic [lkvc_pkg::VALUE_W-1:0] v);
        lkvc_pkg::req_t r;
        r.func  = f;
        r.key   = k;
        r.value = v;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input int count, input logic [lkvc_pkg::CAP_W-1:0] cap);
        int                           span;
        int                           limit;
        logic [lkvc_pkg::KEY_W-1:0]   k;
        logic [lkvc_pkg::VALUE_W-1:0] v;
        lkvc_pkg::func_t              f;
        limit = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
        span  = limit + limit / 2 + 2;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) == 0)
                k = 16'($urandom_range(16'hFFFF));
            else
                k = key_pool[5'($urandom_range(span - 1))];
            case ($urandom_range(9))
                0:       v = '0;
                1:       v = '1;
                default: v = 31'($urandom());
            endcase
            f = ($urandom_range(1) == 1) ? lkvc_pkg::FUNC_PUT : lkvc_pkg::FUNC_GET;
            push_req(f, k, v);
        end
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
        @(negedge clk);
        cfg_wr_data <= cap;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || offer_busy || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        lkvc_pkg::req_t r;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL lru_key_value_cache");
            $finish;
        end
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                capacity_reg = cfg_wr_data;
                clear_cache();
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: found %0d read_value %0h",
                           m_axis_tuser, m_axis_tdata[lkvc_pkg::VALUE_W-1:0]);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[lkvc_pkg::VALUE_W-1:0] !== want.read_value)
                    begin
                        $error("read_value: expected %0h, actual %0h",
                               want.read_value, m_axis_tdata[lkvc_pkg::VALUE_W-1:0]);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                r.func  = lkvc_pkg::func_t'(s_axis_tuser);
                r.key   = s_axis_tdata[lkvc_pkg::KEY_W-1:0];
                r.value = s_axis_tdata[lkvc_pkg::KEY_W+lkvc_pkg::VALUE_W-1:lkvc_pkg::KEY_W];
                expected_results.push_back(cache_access(r));
                req_taken = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        lkvc_pkg::req_t r;
        if (rst_n)
        begin
            if (!s_axis_tvalid || req_taken)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    r = pending_reqs.pop_front();
                    s_axis_tdata  <= {1'b0, r.value, r.key};
                    s_axis_tuser  <= r.func;
                    s_axis_tvalid <= 1'b1;
                    offer_busy = 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    offer_busy = 1'b0;
                end
            end
            req_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        logic [lkvc_pkg::CAP_W-1:0] phase_caps [PHASES];
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd12};
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        req_taken     = 1'b0;
        offer_busy    = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        capacity_reg  = lkvc_pkg::CAP_RESET;
        clear_cache();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 84;
            end
            else if (p < 4)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p > 0)
                write_capacity(phase_caps[p]);
            for (int i = 0; i < 32; i++)
                key_pool[i] = 16'($urandom_range(16'hFFFF));

            if (p == 0)
            begin
                // Extremes, a miss, an update in place, then fill the store and force
                // an eviction of the least recent key.
                push_req(lkvc_pkg::FUNC_PUT, 16'h0000, 31'h0000_0000);
                push_req(lkvc_pkg::FUNC_PUT, 16'hFFFF, 31'h7FFF_FFFF);
                push_req(lkvc_pkg::FUNC_GET, 16'hFFFF, 31'h0000_0000);
                push_req(lkvc_pkg::FUNC_GET, 16'h0000, 31'h7FFF_FFFF);
                push_req(lkvc_pkg::FUNC_GET, 16'h1234, 31'h0000_0000);
                push_req(lkvc_pkg::FUNC_PUT, 16'h0000, 31'h0000_0005);
                push_req(lkvc_pkg::FUNC_GET, 16'h0000, 31'h0000_0000);
                for (int i = 0; i < 14; i++)
                    push_req(lkvc_pkg::FUNC_PUT, 16'(16'h0100 + i), 31'($urandom()));
                push_req(lkvc_pkg::FUNC_PUT, 16'h0200, 31'h2AAA_AAAA);
                push_req(lkvc_pkg::FUNC_GET, 16'hFFFF, 31'h0000_0000);
            end

            if (p == 5)
                hold_requests++;

            if (p == 3)
            begin
                queue_random(75, phase_caps[p]);
                wait_drained();
                queue_random(80, phase_caps[p]);
            end
            else
            begin
                queue_random(155, phase_caps[p]);
            end
            wait_drained();
        end

        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS lru_key_value_cache");
        else
            $display("FAIL lru_key_value_cache");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
verif/tb_top.sv
